// ===== hdl/rlt_pkg.sv =====
// Package for the byte-range lock table: sizes, operation and status codes,
// controller states and the command/status structs between control and datapath.
`timescale 1ns / 1ps

package rlt_pkg;

    localparam int LOCK_SLOTS   = 16;
    localparam int MAX_CHANNELS = 16;
    localparam int FILE_ID_BITS = 8;
    localparam int IDX_BITS     = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;

    typedef enum logic [1:0] {
        FN_LOCK   = 2'd0,
        FN_UNLOCK = 2'd1,
        FN_CHECK  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADCH    = 3'd1,
        ST_OVERLAP  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_SCAN,
        CS_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic finish;
    } rlt_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic rsp_busy;
    } rlt_sts_t;

endpackage

// ===== hdl/range_lock_table_top.sv =====
// Top level of the byte-range lock table: controller plus datapath.
// Depends on rlt_pkg, rlt_ctrl and rlt_dp.
`timescale 1ns / 1ps

// Usage:
//   Request channel: req_valid/req_stall with func, channel, file_id,
//   channel_open, range_start, range_end. An item is taken when req_valid is
//   high and req_stall low. Response channel: rsp_valid/rsp_stall with status.
//   One response item per request item, in order.
//   Sequence per item: capture, then one scan step per lock slot through the
//   slot table, then finish/write-back; status appears in the output register
//   the cycle after finish. req_stall is high while an item is in work, so a
//   new item is taken only after the previous one has reached finish.
//   If the receiver stalls, the result holds in the output register; the next
//   request is still taken and scanned, and waits at finish until the output
//   register is free.
//   Reset (rst_n low, asynchronous) clears all active-slot flags and the
//   controller; no clearing pass is needed, the block is ready right after.
module range_lock_table_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         func,
    input  logic [7:0]         channel,
    input  logic [7:0]         file_id,
    input  logic               channel_open,
    input  logic signed [31:0] range_start,
    input  logic signed [31:0] range_end,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [2:0]         status
);

    rlt_pkg::rlt_cmd_t cmd;
    rlt_pkg::rlt_sts_t sts;

    rlt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    rlt_dp u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .func         (func),
        .channel      (channel),
        .file_id      (file_id),
        .channel_open (channel_open),
        .range_start  (range_start),
        .range_end    (range_end),
        .status       (status),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall)
    );

endmodule

// ===== hdl/rlt_ctrl.sv =====
// Controller for the lock table: capture, slot scan, finish/write-back.
// Depends on rlt_pkg.
`timescale 1ns / 1ps

module rlt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  rlt_pkg::rlt_sts_t sts,
    output rlt_pkg::rlt_cmd_t cmd
);

    rlt_pkg::ctrl_state_t state_reg;
    rlt_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rlt_pkg::CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rlt_pkg::CS_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rlt_pkg::CS_SCAN;
                end
            end
            rlt_pkg::CS_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = rlt_pkg::CS_FINISH;
                end
            end
            rlt_pkg::CS_FINISH:
            begin
                if (!sts.rsp_busy)
                begin
                    state_next = rlt_pkg::CS_IDLE;
                end
            end
            default:
            begin
                state_next = rlt_pkg::CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall     = 1'b1;
        cmd.capture   = 1'b0;
        cmd.scan_step = 1'b0;
        cmd.finish    = 1'b0;
        unique case (state_reg)
            rlt_pkg::CS_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            rlt_pkg::CS_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            rlt_pkg::CS_FINISH:
            begin
                cmd.finish = !sts.rsp_busy;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // finish is only entered from the last scan step
    a_finish_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rlt_pkg::CS_FINISH && $past(state_reg) != rlt_pkg::CS_FINISH)
        |-> $past(sts.scan_last))
        else $error("finish entered without completed scan");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.scan_step, cmd.finish}))
        else $error("more than one datapath command");

endmodule

// ===== hdl/rlt_dp.sv =====
// Datapath for the lock table: request registers, slot store, scan flags,
// finish decision and the output register. Depends on rlt_pkg.
`timescale 1ns / 1ps

module rlt_dp
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  rlt_pkg::rlt_cmd_t        cmd,
    output rlt_pkg::rlt_sts_t        sts,
    input  logic [1:0]               func,
    input  logic [7:0]               channel,
    input  logic [7:0]               file_id,
    input  logic                     channel_open,
    input  logic signed [31:0]       range_start,
    input  logic signed [31:0]       range_end,
    output logic [2:0]               status,
    output logic                     rsp_valid,
    input  logic                     rsp_stall
);

    localparam int FB = rlt_pkg::FILE_ID_BITS;
    localparam int IB = rlt_pkg::IDX_BITS;

    // request
    logic [1:0]         func_reg;
    logic [7:0]         chan_reg;
    logic [FB-1:0]      fid_reg;
    logic               ch_ok_reg;
    logic               open_reg;
    logic signed [31:0] start_reg;
    logic signed [31:0] end_reg;

    // slot store
    logic [rlt_pkg::LOCK_SLOTS-1:0] slot_active_reg;
    logic [7:0]                     slot_owner_reg [rlt_pkg::LOCK_SLOTS];
    logic [FB-1:0]                  slot_file_reg  [rlt_pkg::LOCK_SLOTS];
    logic signed [31:0]             slot_first_reg [rlt_pkg::LOCK_SLOTS];
    logic signed [31:0]             slot_last_reg  [rlt_pkg::LOCK_SLOTS];

    // scan
    logic [IB-1:0] idx_reg;
    logic          conflict_reg;
    logic          free_found_reg;
    logic [IB-1:0] free_idx_reg;
    logic          match_found_reg;
    logic [IB-1:0] match_idx_reg;

    logic               rd_active;
    logic [7:0]         rd_owner;
    logic [FB-1:0]      rd_file;
    logic signed [31:0] rd_first;
    logic signed [31:0] rd_last;
    logic               hit_conflict;
    logic               hit_match;

    // finish
    rlt_pkg::status_t fin_status;
    logic             fin_write;
    logic             fin_clear;

    // output
    logic [2:0] status_reg;
    logic       rsp_valid_reg;

    assign sts.scan_last = (idx_reg == IB'(rlt_pkg::LOCK_SLOTS - 1));
    assign sts.rsp_busy  = rsp_valid_reg && rsp_stall;

    assign rd_active = slot_active_reg[idx_reg];
    assign rd_owner  = slot_owner_reg[idx_reg];
    assign rd_file   = slot_file_reg[idx_reg];
    assign rd_first  = slot_first_reg[idx_reg];
    assign rd_last   = slot_last_reg[idx_reg];

    assign hit_conflict = rd_active && (rd_owner != chan_reg) && (rd_file == fid_reg)
                          && !((end_reg < rd_first) || (start_reg > rd_last));
    assign hit_match    = rd_active && (rd_owner == chan_reg)
                          && (rd_first == start_reg) && (rd_last == end_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            chan_reg  <= channel;
            fid_reg   <= file_id[FB-1:0];
            ch_ok_reg <= (channel != 8'd0) && (channel <= 8'(rlt_pkg::MAX_CHANNELS));
            open_reg  <= channel_open;
            start_reg <= range_start;
            end_reg   <= range_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            conflict_reg    <= 1'b0;
            free_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            idx_reg         <= '0;
            conflict_reg    <= 1'b0;
            free_found_reg  <= 1'b0;
            match_found_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (hit_conflict)
            begin
                conflict_reg <= 1'b1;
            end
            if (!rd_active && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (hit_match && !match_found_reg)
            begin
                match_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_step && !rd_active && !free_found_reg)
        begin
            free_idx_reg <= idx_reg;
        end
        if (cmd.scan_step && hit_match && !match_found_reg)
        begin
            match_idx_reg <= idx_reg;
        end
    end

    always_comb
    begin
        fin_status = rlt_pkg::ST_OK;
        fin_write  = 1'b0;
        fin_clear  = 1'b0;
        unique case (func_reg)
            rlt_pkg::FN_LOCK:
            begin
                if (!ch_ok_reg || !open_reg)
                begin
                    fin_status = rlt_pkg::ST_BADCH;
                end
                else if (conflict_reg)
                begin
                    fin_status = rlt_pkg::ST_OVERLAP;
                end
                else if (!free_found_reg)
                begin
                    fin_status = rlt_pkg::ST_FULL;
                end
                else
                begin
                    fin_write = 1'b1;
                end
            end
            rlt_pkg::FN_UNLOCK:
            begin
                if (!ch_ok_reg)
                begin
                    fin_status = rlt_pkg::ST_BADCH;
                end
                else if (match_found_reg)
                begin
                    fin_clear = 1'b1;
                end
                else
                begin
                    fin_status = rlt_pkg::ST_NOTFOUND;
                end
            end
            rlt_pkg::FN_CHECK:
            begin
                if (ch_ok_reg && open_reg && conflict_reg)
                begin
                    fin_status = rlt_pkg::ST_OVERLAP;
                end
            end
            default:
            begin
                fin_status = rlt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_active_reg <= '0;
        end
        else if (cmd.finish && fin_write)
        begin
            slot_active_reg[free_idx_reg] <= 1'b1;
        end
        else if (cmd.finish && fin_clear)
        begin
            slot_active_reg[match_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish && fin_write)
        begin
            slot_owner_reg[free_idx_reg] <= chan_reg;
            slot_file_reg[free_idx_reg]  <= fid_reg;
            slot_first_reg[free_idx_reg] <= start_reg;
            slot_last_reg[free_idx_reg]  <= end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= fin_status;
        end
    end

    assign status    = status_reg;
    assign rsp_valid = rsp_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(rsp_valid_reg && rsp_stall))
        else $error("result overwritten while stalled");

    a_free_is_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_step && free_found_reg) |-> !slot_active_reg[free_idx_reg])
        else $error("recorded free slot is active");

    a_lock_takes_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && fin_write) |=> slot_active_reg[$past(free_idx_reg)])
        else $error("granted lock left slot inactive");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.finish))
        else $error("result without finish");

endmodule

// ===== sim/rlt_checker.sv =====
// Result checker for the byte-range lock table: mirrors the slot table, works out the
// status of every accepted request item and compares it with the response items.
// Depends on rlt_pkg.
`timescale 1ns / 1ps

module rlt_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic [1:0]         func,
    input  logic [7:0]         channel,
    input  logic [7:0]         file_id,
    input  logic               channel_open,
    input  logic signed [31:0] range_start,
    input  logic signed [31:0] range_end,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  logic [2:0]         status,
    output int                 errors,
    output int                 pending,
    output int                 checked
);

    localparam logic [7:0] FID_MASK = 8'((64'd1 << rlt_pkg::FILE_ID_BITS) - 64'd1);

    logic               slot_busy [rlt_pkg::LOCK_SLOTS];
    logic [7:0]         slot_chan [rlt_pkg::LOCK_SLOTS];
    logic [7:0]         slot_fid  [rlt_pkg::LOCK_SLOTS];
    logic signed [31:0] slot_lo   [rlt_pkg::LOCK_SLOTS];
    logic signed [31:0] slot_hi   [rlt_pkg::LOCK_SLOTS];
    rlt_pkg::status_t   status_due [$];

    function automatic logic foreign_overlap(input logic [7:0] ch, input logic [7:0] fid,
                                             input logic signed [31:0] lo,
                                             input logic signed [31:0] hi);
        for (int i = 0; i < rlt_pkg::LOCK_SLOTS; i++)
        begin
            if (slot_busy[i] && slot_chan[i] != ch && slot_fid[i] == fid &&
                !(hi < slot_lo[i] || lo > slot_hi[i]))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // applies one request to the mirrored table and returns its status
    function automatic rlt_pkg::status_t settle_request(input logic [1:0] op,
                                                        input logic [7:0] ch,
                                                        input logic [7:0] fid_in,
                                                        input logic open,
                                                        input logic signed [31:0] lo,
                                                        input logic signed [31:0] hi);
        logic [7:0]       fid;
        logic             ch_ok;
        rlt_pkg::status_t st;
        fid   = fid_in & FID_MASK;
        ch_ok = (ch >= 1) && (ch <= rlt_pkg::MAX_CHANNELS);
        st    = rlt_pkg::ST_OK;
        case (op)
            rlt_pkg::FN_LOCK:
            begin
                if (!ch_ok || !open)
                    st = rlt_pkg::ST_BADCH;
                else if (foreign_overlap(ch, fid, lo, hi))
                    st = rlt_pkg::ST_OVERLAP;
                else
                begin
                    st = rlt_pkg::ST_FULL;
                    for (int i = 0; i < rlt_pkg::LOCK_SLOTS && st == rlt_pkg::ST_FULL; i++)
                    begin
                        if (!slot_busy[i])
                        begin
                            slot_busy[i] = 1'b1;
                            slot_chan[i] = ch;
                            slot_fid[i]  = fid;
                            slot_lo[i]   = lo;
                            slot_hi[i]   = hi;
                            st           = rlt_pkg::ST_OK;
                        end
                    end
                end
            end
            rlt_pkg::FN_UNLOCK:
            begin
                if (!ch_ok)
                    st = rlt_pkg::ST_BADCH;
                else
                begin
                    st = rlt_pkg::ST_NOTFOUND;
                    for (int i = 0;
                         i < rlt_pkg::LOCK_SLOTS && st == rlt_pkg::ST_NOTFOUND; i++)
                    begin
                        if (slot_busy[i] && slot_chan[i] == ch &&
                            slot_lo[i] == lo && slot_hi[i] == hi)
                        begin
                            slot_busy[i] = 1'b0;
                            st           = rlt_pkg::ST_OK;
                        end
                    end
                end
            end
            rlt_pkg::FN_CHECK:
            begin
                if (ch_ok && open && foreign_overlap(ch, fid, lo, hi))
                    st = rlt_pkg::ST_OVERLAP;
            end
            default:
                st = rlt_pkg::ST_OK;
        endcase
        return st;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rlt_pkg::LOCK_SLOTS; i++)
                slot_busy[i] = 1'b0;
            status_due.delete();
            errors  <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (status_due.size() == 0)
                begin
                    $error("unexpected response item: status %0d", status);
                    errors <= errors + 1;
                end
                else
                begin
                    if (status !== status_due[0])
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               status_due[0], status);
                        errors <= errors + 1;
                    end
                    void'(status_due.pop_front());
                    checked <= checked + 1;
                end
            end
            if (req_valid && !req_stall)
                status_due.push_back(settle_request(func, channel, file_id, channel_open,
                                                    range_start, range_end));
            pending <= status_due.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for range_lock_table_top: drives request items, random response stalls
// and a watchdog, and prints the verdict. Depends on rlt_pkg, rlt_checker and the RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] FN_UNUSED        = 2'd3;
    localparam int         RANDOM_PER_PHASE = 283;
    localparam int         QUIET_LIMIT      = 2000;
    localparam int         DRAIN_CYCLES     = 40;
    localparam logic signed [31:0] POS_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] POS_MAX  = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [7:0]         ch;
        logic [7:0]         fid;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } lock_req_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               req_valid    = 1'b0;
    logic               req_stall;
    logic [1:0]         func         = rlt_pkg::FN_LOCK;
    logic [7:0]         channel      = 8'd0;
    logic [7:0]         file_id      = 8'd0;
    logic               channel_open = 1'b0;
    logic signed [31:0] range_start  = 32'sd0;
    logic signed [31:0] range_end    = 32'sd0;
    logic               rsp_valid;
    logic               rsp_stall    = 1'b0;
    logic [2:0]         status;

    int        errors;
    int        pending;
    int        checked;
    int        send_idle_pct = 25;
    int        rcv_idle_pct  = 65;
    int        quiet_cycles  = 0;
    int        op_count [4]  = '{0, 0, 0, 0};
    lock_req_t recent_locks [$];

    range_lock_table_top dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .channel      (channel),
        .file_id      (file_id),
        .channel_open (channel_open),
        .range_start  (range_start),
        .range_end    (range_end),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status)
    );

    rlt_checker u_lock_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .func         (func),
        .channel      (channel),
        .file_id      (file_id),
        .channel_open (channel_open),
        .range_start  (range_start),
        .range_end    (range_end),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < rcv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("range_lock_table_top test failed");
        $finish;
    end

    task automatic send(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] fid,
                        input logic open, input logic signed [31:0] lo,
                        input logic signed [31:0] hi);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid    <= 1'b1;
        func         <= op;
        channel      <= ch;
        file_id      <= fid;
        channel_open <= open;
        range_start  <= lo;
        range_end    <= hi;
        do @(posedge clk); while (req_stall);
        op_count[op]++;
    endtask

    // mostly valid channels, a handful of files, ranges that collide often
    function automatic lock_req_t make_range();
        lock_req_t r;
        r.ch  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(1, rlt_pkg::MAX_CHANNELS));
        r.fid = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(1, 3));
        case ($urandom_range(0, 9))
            0:
            begin
                r.lo = $urandom;
                r.hi = $urandom;
            end
            1:
            begin
                r.lo = POS_MIN + $urandom_range(0, 64);
                r.hi = r.lo + $urandom_range(0, 64);
            end
            2:
            begin
                r.hi = POS_MAX - $urandom_range(0, 64);
                r.lo = r.hi - $urandom_range(0, 64);
            end
            3:
            begin
                r.lo = $urandom_range(0, 255);
                r.hi = r.lo - $urandom_range(1, 16);
            end
            default:
            begin
                r.lo = $urandom_range(0, 31) * 8;
                r.hi = r.lo + $urandom_range(0, 20);
            end
        endcase
        return r;
    endfunction

    task automatic random_request();
        int        pick;
        int        k;
        lock_req_t r;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            send(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), $urandom, $urandom);
        else if (pick < 55)
        begin
            r = make_range();
            send(rlt_pkg::FN_LOCK, r.ch, r.fid, $urandom_range(0, 19) != 0, r.lo, r.hi);
            recent_locks.push_back(r);
            if (recent_locks.size() > 24)
                void'(recent_locks.pop_front());
        end
        else if (pick < 80)
        begin
            if (recent_locks.size() != 0)
            begin
                k = $urandom_range(0, recent_locks.size() - 1);
                r = recent_locks[k];
                recent_locks.delete(k);
                if ($urandom_range(0, 4) == 0)
                    r.hi = r.hi + 1;
            end
            else
                r = make_range();
            send(rlt_pkg::FN_UNLOCK, r.ch, r.fid, 1'($urandom_range(0, 1)), r.lo, r.hi);
        end
        else
        begin
            r = make_range();
            send(rlt_pkg::FN_CHECK, r.ch, r.fid, $urandom_range(0, 9) != 0, r.lo, r.hi);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(rlt_pkg::FN_UNLOCK, 8'd1, 8'd1, 1'b1, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_LOCK, 8'd0, 8'd1, 1'b1, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_LOCK, 8'd17, 8'd1, 1'b1, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_LOCK, 8'd255, 8'd1, 1'b1, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_LOCK, 8'd1, 8'd1, 1'b0, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_LOCK, 8'd1, 8'd1, 1'b1, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_LOCK, 8'd2, 8'd1, 1'b1, 32'sd199, 32'sd300);
        send(rlt_pkg::FN_LOCK, 8'd2, 8'd1, 1'b1, 32'sd200, 32'sd300);
        send(rlt_pkg::FN_LOCK, 8'd2, 8'd1, 1'b1, 32'sd0, 32'sd99);
        send(rlt_pkg::FN_LOCK, 8'd2, 8'd2, 1'b1, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_LOCK, 8'd1, 8'd1, 1'b1, 32'sd150, 32'sd160);
        send(rlt_pkg::FN_LOCK, 8'd3, 8'd1, 1'b1, 32'sd250, 32'sd50);
        send(rlt_pkg::FN_CHECK, 8'd3, 8'd1, 1'b1, 32'sd120, 32'sd120);
        send(rlt_pkg::FN_CHECK, 8'd3, 8'd1, 1'b0, 32'sd120, 32'sd120);
        send(rlt_pkg::FN_CHECK, 8'd0, 8'd1, 1'b1, 32'sd120, 32'sd120);
        send(FN_UNUSED, 8'd1, 8'd1, 1'b1, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_LOCK, 8'd16, 8'hFF, 1'b1, POS_MIN, POS_MAX);
        send(rlt_pkg::FN_LOCK, 8'd15, 8'hFF, 1'b1, 32'sd0, 32'sd0);
        send(rlt_pkg::FN_UNLOCK, 8'd1, 8'd9, 1'b0, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_UNLOCK, 8'd1, 8'd1, 1'b1, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_UNLOCK, 8'd0, 8'd1, 1'b1, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_UNLOCK, 8'd17, 8'd1, 1'b1, 32'sd100, 32'sd199);
        send(rlt_pkg::FN_CHECK, 8'd15, 8'hFF, 1'b1, POS_MAX, POS_MAX);
        send(rlt_pkg::FN_UNLOCK, 8'd16, 8'hFF, 1'b1, POS_MIN, POS_MAX);

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 65 : 0;
            rcv_idle_pct <= (phase == 0) ? 65 : (phase == 1) ? 25 : 0;
            repeat (RANDOM_PER_PHASE) random_request();
        end

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d lock, %0d unlock, %0d check, %0d unused op",
                 op_count[0] + op_count[1] + op_count[2] + op_count[3],
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("%0d responses checked under three sender/receiver idling mixes", checked);
        if (errors == 0 && pending == 0)
            $display("range_lock_table_top test passed");
        else
            $display("range_lock_table_top test failed");
        $finish;
    end

endmodule
